FILE: rtl/ucs_pkg.sv
package ucs_pkg;

    // Width of every saturating counter and of the byte offsets.
    localparam int COUNT_WIDTH = 32;

    localparam int CMD_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int LENGTH_W = 3;

    // Counter store layout.
    localparam int NUM_CLASSES = 6;
    localparam int NUM_TRANS   = 9;
    localparam int CLS_ADDR_W  = $clog2(NUM_CLASSES);
    localparam int TRN_ADDR_W  = $clog2(NUM_TRANS);

    // Counter index map of the read command.
    localparam logic [INDEX_W-1:0] IDX_TRANS_BASE = INDEX_W'(NUM_CLASSES);
    localparam logic [INDEX_W-1:0] IDX_BYTES      = INDEX_W'(NUM_CLASSES + NUM_TRANS);
    localparam logic [INDEX_W-1:0] IDX_CHARS      = INDEX_W'(NUM_CLASSES + NUM_TRANS + 1);

    // Stream bytes with a class of their own.
    localparam logic [BYTE_W-1:0] BYTE_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] BYTE_CR = 8'h0D;

    // Coarse classes used for the transition matrix.
    localparam logic [1:0] COARSE_LF   = 2'd0;
    localparam logic [1:0] COARSE_CR   = 2'd1;
    localparam logic [1:0] COARSE_CHAR = 2'd2;

    // Class counter addresses.
    localparam logic [CLS_ADDR_W-1:0] CLS_LF     = CLS_ADDR_W'(0);
    localparam logic [CLS_ADDR_W-1:0] CLS_CR     = CLS_ADDR_W'(1);
    localparam logic [CLS_ADDR_W-1:0] CLS_BYTE1  = CLS_ADDR_W'(2);

    typedef logic [COUNT_WIDTH-1:0] t_cnt;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ERR_NONE = 2'd0,
        ERR_LEAD = 2'd1,
        ERR_CONT = 2'd2
    } t_err;

    // Source of the value returned by a read.
    typedef enum logic [1:0] {
        RD_NONE,
        RD_CLS,
        RD_TRN,
        RD_REG
    } t_rd_src;

    // One word in the memory stage.
    typedef struct packed {
        t_rd_src                 rd_src;
        logic                    cls_inc;
        logic [CLS_ADDR_W-1:0]   cls_addr;
        logic                    trn_inc;
        logic [TRN_ADDR_W-1:0]   trn_addr;
        t_cnt                    reg_val;
        logic [STATUS_W-1:0]     err_status;
        t_cnt                    err_offset;
        logic [LENGTH_W-1:0]     err_len;
    } t_s1;

    function automatic t_cnt sat_inc(input t_cnt v);
        return (&v) ? v : t_cnt'(v + 1'b1);
    endfunction

endpackage

FILE: rtl/ucs_if.sv
// Input channel: one command word per handshake.
interface ucs_in_if;
    logic                         valid;
    logic                         ready;
    logic [ucs_pkg::CMD_W-1:0]    command;
    logic [ucs_pkg::BYTE_W-1:0]   data_byte;
    logic [ucs_pkg::INDEX_W-1:0]  counter_index;

    modport source (output valid, command, data_byte, counter_index, input ready);
    modport sink   (input valid, command, data_byte, counter_index, output ready);
endinterface

// Output channel: one result word per handshake.
interface ucs_out_if;
    logic                          valid;
    logic                          ready;
    logic [ucs_pkg::VALUE_W-1:0]   read_value;
    logic [ucs_pkg::STATUS_W-1:0]  error_status;
    logic [ucs_pkg::VALUE_W-1:0]   error_offset;
    logic [ucs_pkg::LENGTH_W-1:0]  error_length;

    modport source (output valid, read_value, error_status, error_offset, error_length,
                    input ready);
    modport sink   (input valid, read_value, error_status, error_offset, error_length,
                    output ready);
endinterface

FILE: rtl/utf8_char_class_statistics_core.sv
// UTF-8 validator with a character class histogram. Every input word (push a byte,
// read a counter, clear) returns exactly one result word by way of the memory stage
// and the output register, and a new word is taken every cycle as long as the output
// side drains. The decoder and the totals sit in flip-flops and are updated as a word
// is taken; the six class counters and the nine transition counters live in two small
// memories that are read when the word is taken and incremented and written back
// as the word leaves the memory stage, with the written value forwarded to a word
// that reads the same entry right behind it. A clear takes effect at once through one
// valid bit per counter entry, so no sweep of the memories is needed. Counters
// saturate; a read returns their low 32 bits.
module utf8_char_class_statistics_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ucs_in_if.sink    i_in,
    ucs_out_if.source o_out
);
    import ucs_pkg::*;

    // Decoder and total registers.
    logic [1:0]            r_prev;
    logic                  r_have_prev;
    logic [1:0]            r_sfx_rem;
    logic [1:0]            r_sfx_tot;
    t_cnt                  r_lead_off;
    t_cnt                  r_byte_total;
    t_cnt                  r_char_total;
    logic [STATUS_W-1:0]   r_err_status;
    t_cnt                  r_err_off;
    logic [LENGTH_W-1:0]   r_err_len;

    logic [1:0]            n_prev;
    logic                  n_have_prev;
    logic [1:0]            n_sfx_rem;
    logic [1:0]            n_sfx_tot;
    t_cnt                  n_lead_off;
    t_cnt                  n_byte_total;
    t_cnt                  n_char_total;
    logic [STATUS_W-1:0]   n_err_status;
    t_cnt                  n_err_off;
    logic [LENGTH_W-1:0]   n_err_len;

    // Counter memories, their read registers and valid bits.
    t_cnt                  r_cls_mem [NUM_CLASSES];
    t_cnt                  r_trn_mem [NUM_TRANS];
    t_cnt                  r_cls_rd;
    t_cnt                  r_trn_rd;
    logic [NUM_CLASSES-1:0] r_cls_vld;
    logic [NUM_TRANS-1:0]   r_trn_vld;
    logic                  r_cls_byp;
    logic                  r_trn_byp;
    t_cnt                  r_cls_byp_val;
    t_cnt                  r_trn_byp_val;

    // Memory stage and output register.
    logic                  r_s1_valid;
    t_s1                   r_s1;
    t_s1                   n_s1;
    logic                  r_o_valid;
    logic [VALUE_W-1:0]    r_o_value;
    logic [STATUS_W-1:0]   r_o_status;
    logic [VALUE_W-1:0]    r_o_offset;
    logic [LENGTH_W-1:0]   r_o_length;

    logic                  w_advance;
    logic                  w_accept;
    logic                  w_clear;
    t_cmd                  w_cmd;
    logic                  w_fin;
    logic [1:0]            w_fin_coarse;
    logic [CLS_ADDR_W-1:0] w_fin_cls;
    logic [1:0]            w_lead_n;
    logic                  w_lead_bad;
    t_cnt                  w_bt_inc;
    logic                  w_cls_we;
    logic                  w_trn_we;
    t_cnt                  w_cls_cur;
    t_cnt                  w_trn_cur;
    t_cnt                  w_cls_new;
    t_cnt                  w_trn_new;
    logic [VALUE_W-1:0]    w_read_value;

    // Handshake: the memory stage moves whenever the output register is free.
    assign w_advance = !r_o_valid || o_out.ready;
    assign i_in.ready = !r_s1_valid || w_advance;
    assign w_accept  = i_in.valid && i_in.ready;
    assign w_cmd     = t_cmd'(i_in.command);
    assign w_clear   = w_accept && (w_cmd == CMD_CLEAR);
    assign w_bt_inc  = sat_inc(r_byte_total);

    // Lead byte decode: number of continuation bytes, or a bad lead.
    always_comb begin
        w_lead_n   = 2'd0;
        w_lead_bad = 1'b0;
        priority if (!i_in.data_byte[7]) begin
            w_lead_n = 2'd0;
        end else if (i_in.data_byte[7:5] == 3'b110) begin
            w_lead_n = 2'd1;
        end else if (i_in.data_byte[7:4] == 4'b1110) begin
            w_lead_n = 2'd2;
        end else if (i_in.data_byte[7:3] == 5'b11110) begin
            w_lead_n = 2'd3;
        end else begin
            w_lead_bad = 1'b1;
        end
    end

    // Decoder step and request for the memory stage.
    always_comb begin
        n_prev       = r_prev;
        n_have_prev  = r_have_prev;
        n_sfx_rem    = r_sfx_rem;
        n_sfx_tot    = r_sfx_tot;
        n_lead_off   = r_lead_off;
        n_byte_total = r_byte_total;
        n_char_total = r_char_total;
        n_err_status = r_err_status;
        n_err_off    = r_err_off;
        n_err_len    = r_err_len;
        w_fin        = 1'b0;
        w_fin_coarse = COARSE_CHAR;
        w_fin_cls    = CLS_BYTE1;
        n_s1         = '0;
        n_s1.rd_src  = RD_NONE;

        if (w_accept) begin
            unique case (w_cmd)
                CMD_PUSH: begin
                    if (r_err_status == ERR_NONE) begin
                        n_byte_total = w_bt_inc;
                        if (r_sfx_rem != 2'd0) begin
                            // Inside a character: expect a continuation byte.
                            if (i_in.data_byte[7:6] != 2'b10) begin
                                n_err_status = ERR_CONT;
                                n_err_off    = r_lead_off;
                                n_err_len    = 3'd2 + LENGTH_W'(r_sfx_tot - r_sfx_rem);
                                n_sfx_rem    = 2'd0;
                                n_sfx_tot    = 2'd0;
                            end else begin
                                n_sfx_rem = r_sfx_rem - 2'd1;
                                if (r_sfx_rem == 2'd1) begin
                                    w_fin     = 1'b1;
                                    w_fin_cls = CLS_BYTE1 + CLS_ADDR_W'(r_sfx_tot);
                                end
                            end
                        end else if (i_in.data_byte == BYTE_LF) begin
                            w_fin        = 1'b1;
                            w_fin_coarse = COARSE_LF;
                            w_fin_cls    = CLS_LF;
                        end else if (i_in.data_byte == BYTE_CR) begin
                            w_fin        = 1'b1;
                            w_fin_coarse = COARSE_CR;
                            w_fin_cls    = CLS_CR;
                        end else begin
                            n_lead_off = w_bt_inc;
                            if (w_lead_bad) begin
                                n_err_status = ERR_LEAD;
                                n_err_off    = w_bt_inc;
                                n_err_len    = 3'd1;
                            end else if (w_lead_n == 2'd0) begin
                                w_fin = 1'b1;
                            end else begin
                                n_sfx_rem = w_lead_n;
                                n_sfx_tot = w_lead_n;
                            end
                        end
                    end
                end
                CMD_READ: begin
                    priority if (i_in.counter_index < IDX_TRANS_BASE) begin
                        n_s1.rd_src   = RD_CLS;
                        n_s1.cls_addr = CLS_ADDR_W'(i_in.counter_index);
                    end else if (i_in.counter_index < IDX_BYTES) begin
                        n_s1.rd_src   = RD_TRN;
                        n_s1.trn_addr = TRN_ADDR_W'(i_in.counter_index - IDX_TRANS_BASE);
                    end else if (i_in.counter_index == IDX_BYTES) begin
                        n_s1.rd_src  = RD_REG;
                        n_s1.reg_val = r_byte_total;
                    end else if (i_in.counter_index == IDX_CHARS) begin
                        n_s1.rd_src  = RD_REG;
                        n_s1.reg_val = r_char_total;
                    end else begin
                        n_s1.rd_src = RD_NONE;
                    end
                end
                CMD_CLEAR: begin
                    n_prev       = 2'd0;
                    n_have_prev  = 1'b0;
                    n_sfx_rem    = 2'd0;
                    n_sfx_tot    = 2'd0;
                    n_lead_off   = '0;
                    n_byte_total = '0;
                    n_char_total = '0;
                    n_err_status = ERR_NONE;
                    n_err_off    = '0;
                    n_err_len    = '0;
                end
                CMD_NOP: begin
                end
                default: begin
                end
            endcase
        end

        // A completed character bumps its class and, after the first, a transition.
        if (w_fin) begin
            n_s1.cls_inc  = 1'b1;
            n_s1.cls_addr = w_fin_cls;
            n_char_total  = sat_inc(r_char_total);
            if (r_have_prev) begin
                n_s1.trn_inc  = 1'b1;
                n_s1.trn_addr = TRN_ADDR_W'(r_prev) * TRN_ADDR_W'(3)
                              + TRN_ADDR_W'(w_fin_coarse);
            end
            n_prev      = w_fin_coarse;
            n_have_prev = 1'b1;
        end

        n_s1.err_status = n_err_status;
        n_s1.err_offset = n_err_off;
        n_s1.err_len    = n_err_len;
    end

    // Decoder and total registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev       <= 2'd0;
            r_have_prev  <= 1'b0;
            r_sfx_rem    <= 2'd0;
            r_sfx_tot    <= 2'd0;
            r_lead_off   <= '0;
            r_byte_total <= '0;
            r_char_total <= '0;
            r_err_status <= ERR_NONE;
            r_err_off    <= '0;
            r_err_len    <= '0;
        end else begin
            r_prev       <= n_prev;
            r_have_prev  <= n_have_prev;
            r_sfx_rem    <= n_sfx_rem;
            r_sfx_tot    <= n_sfx_tot;
            r_lead_off   <= n_lead_off;
            r_byte_total <= n_byte_total;
            r_char_total <= n_char_total;
            r_err_status <= n_err_status;
            r_err_off    <= n_err_off;
            r_err_len    <= n_err_len;
        end
    end

    // Read-modify-write in the memory stage.
    assign w_cls_cur = r_cls_byp ? r_cls_byp_val : r_cls_rd;
    assign w_trn_cur = r_trn_byp ? r_trn_byp_val : r_trn_rd;
    assign w_cls_new = sat_inc(w_cls_cur);
    assign w_trn_new = sat_inc(w_trn_cur);
    assign w_cls_we  = r_s1_valid && w_advance && r_s1.cls_inc;
    assign w_trn_we  = r_s1_valid && w_advance && r_s1.trn_inc;

    // Counter memories: one write and one registered read each.
    always_ff @(posedge i_clk) begin
        if (w_cls_we) begin
            r_cls_mem[r_s1.cls_addr] <= w_cls_new;
        end
        if (w_trn_we) begin
            r_trn_mem[r_s1.trn_addr] <= w_trn_new;
        end
        if (w_accept) begin
            r_cls_rd <= r_cls_mem[n_s1.cls_addr];
            r_trn_rd <= r_trn_mem[n_s1.trn_addr];
        end
    end

    // Bypass: forward a write to the same entry, or read a cleared entry as zero.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (w_cls_we && (r_s1.cls_addr == n_s1.cls_addr)) begin
                r_cls_byp     <= 1'b1;
                r_cls_byp_val <= w_cls_new;
            end else begin
                r_cls_byp     <= !r_cls_vld[n_s1.cls_addr];
                r_cls_byp_val <= '0;
            end
            if (w_trn_we && (r_s1.trn_addr == n_s1.trn_addr)) begin
                r_trn_byp     <= 1'b1;
                r_trn_byp_val <= w_trn_new;
            end else begin
                r_trn_byp     <= !r_trn_vld[n_s1.trn_addr];
                r_trn_byp_val <= '0;
            end
        end
    end

    // Entry valid bits; a clear wins over a write in the same cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cls_vld <= '0;
            r_trn_vld <= '0;
        end else begin
            if (w_cls_we) begin
                r_cls_vld[r_s1.cls_addr] <= 1'b1;
            end
            if (w_trn_we) begin
                r_trn_vld[r_s1.trn_addr] <= 1'b1;
            end
            if (w_clear) begin
                r_cls_vld <= '0;
                r_trn_vld <= '0;
            end
        end
    end

    // Memory stage control: the stage loads whenever it can take a word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1 <= n_s1;
        end
    end

    // Select the read value.
    always_comb begin
        unique case (r_s1.rd_src)
            RD_CLS:  w_read_value = VALUE_W'(w_cls_cur);
            RD_TRN:  w_read_value = VALUE_W'(w_trn_cur);
            RD_REG:  w_read_value = VALUE_W'(r_s1.reg_val);
            RD_NONE: w_read_value = '0;
            default: w_read_value = '0;
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_advance) begin
            r_o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_s1_valid) begin
            r_o_value  <= w_read_value;
            r_o_status <= r_s1.err_status;
            r_o_offset <= VALUE_W'(r_s1.err_offset);
            r_o_length <= r_s1.err_len;
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.read_value   = r_o_value;
    assign o_out.error_status = r_o_status;
    assign o_out.error_offset = r_o_offset;
    assign o_out.error_length = r_o_length;

`ifndef SYNTHESIS
    // A latched error holds until a clear is taken.
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err_status != ERR_NONE) && !w_clear |=> (r_err_status == $past(r_err_status)))
        else $error("latched error changed without a clear");

    // Error status and length agree.
    a_err_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err_status == ERR_NONE) == (r_err_len == '0))
        else $error("error length does not match error status");

    // The pending count never exceeds the character length.
    a_sfx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sfx_rem <= r_sfx_tot)
        else $error("continuation count exceeds character length");

    // No word is taken while the memory stage is stalled.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> (!r_s1_valid || w_advance))
        else $error("word accepted into a stalled memory stage");

    // Transition updates only follow an earlier character.
    a_trn_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && n_s1.trn_inc |-> r_have_prev)
        else $error("transition counted without a previous character");
`endif

endmodule
